// ----- rtl/sis_pkg.sv -----
// ----------------------------------------------------------------------------
// sis_pkg
// shared types and codes of the sorted interval set table
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int MAX_INTERVALS_DEF = 16;
	localparam int NUMBER_BITS_DEF   = 32;
	localparam int FIELD_BITS        = 32;
	localparam int COUNT_OUT_BITS    = 5;

	localparam logic [1:0] FUNC_ADD    = 2'd0;
	localparam logic [1:0] FUNC_REMOVE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] STATUS_DONE     = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_REVERSED = 2'd2;

	typedef enum logic [2:0] {
		M_HOLD,
		M_EVAL_ADD,
		M_EVAL_REM,
		M_INSERT,
		M_MERGE,
		M_CUT,
		M_SWAP_EVEN,
		M_SWAP_ODD
	} cell_mode_t;

	typedef struct packed {
		logic live;
		logic t;
		logic g;
		logic split;
	} cell_flags_t;

endpackage

// ----- rtl/sis_cell.sv -----
// ----------------------------------------------------------------------------
// sis_cell
// one table slot: holds an interval, classifies it against the request
// and trades contents with its neighbors
// ----------------------------------------------------------------------------
module sis_cell import sis_pkg::*; #(
	parameter int NUMBER_BITS = NUMBER_BITS_DEF,
	parameter bit IDX_ODD     = 1'b0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cell_mode_t             mode,
	input  logic [NUMBER_BITS-1:0] a,
	input  logic [NUMBER_BITS-1:0] b,
	input  logic [NUMBER_BITS-1:0] hi_last,
	input  logic [NUMBER_BITS-1:0] prev_lo,
	input  logic [NUMBER_BITS-1:0] prev_hi,
	input  cell_flags_t            prev_f,
	input  logic [NUMBER_BITS-1:0] next_lo,
	input  logic [NUMBER_BITS-1:0] next_hi,
	input  cell_flags_t            next_f,
	output logic [NUMBER_BITS-1:0] lo,
	output logic [NUMBER_BITS-1:0] hi,
	output cell_flags_t            f,
	output logic                   member,
	output logic                   last_t
);

	logic [NUMBER_BITS-1:0] lo_q, hi_q, lo_d, hi_d;
	logic                   live_q, live_d;
	logic                   t_q, g_q, split_q, keep_l_q, keep_r_q, member_q;
	logic                   below_add, below_rem, t_add, t_rem;
	logic                   keep_l, keep_r;

	assign lo     = lo_q;
	assign hi     = hi_q;
	assign f      = '{live: live_q, t: t_q, g: g_q, split: split_q};
	assign member = member_q;
	assign last_t = t_q & ~next_f.t;

	assign below_add = live_q &
		(({1'b0, hi_q} + (NUMBER_BITS+1)'(1)) < {1'b0, a});
	assign t_add     = live_q & ~below_add &
		({1'b0, lo_q} <= ({1'b0, b} + (NUMBER_BITS+1)'(1)));
	assign below_rem = live_q & (hi_q < a);
	assign t_rem     = live_q & ~below_rem & (lo_q <= b);
	assign keep_l    = lo_q < a;
	assign keep_r    = hi_q > b;

	always_comb begin
		lo_d   = lo_q;
		hi_d   = hi_q;
		live_d = live_q;
		unique case (mode)
			M_INSERT: begin
				if (g_q) begin
					if (prev_f.g) begin
						if (prev_f.split) begin
							lo_d   = b + NUMBER_BITS'(1);
							hi_d   = prev_hi;
							live_d = 1'b1;
						end else begin
							lo_d   = prev_lo;
							hi_d   = prev_hi;
							live_d = prev_f.live;
						end
					end else if (split_q) begin
						hi_d = a - NUMBER_BITS'(1);
					end else begin
						lo_d   = a;
						hi_d   = b;
						live_d = 1'b1;
					end
				end
			end
			M_MERGE: begin
				if (t_q) begin
					if (!prev_f.t) begin
						lo_d = (lo_q < a) ? lo_q : a;
						hi_d = (hi_last > b) ? hi_last : b;
					end else begin
						live_d = 1'b0;
					end
				end
			end
			M_CUT: begin
				if (t_q) begin
					if (keep_l_q) begin
						hi_d = a - NUMBER_BITS'(1);
					end else if (keep_r_q) begin
						lo_d = b + NUMBER_BITS'(1);
					end else begin
						live_d = 1'b0;
					end
				end
			end
			M_SWAP_EVEN, M_SWAP_ODD: begin
				if (IDX_ODD == (mode == M_SWAP_ODD)) begin
					if (!live_q && next_f.live) begin
						lo_d   = next_lo;
						hi_d   = next_hi;
						live_d = 1'b1;
					end
				end else if (!prev_f.live && live_q) begin
					live_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q   <= 1'b0;
			t_q      <= 1'b0;
			g_q      <= 1'b0;
			split_q  <= 1'b0;
			keep_l_q <= 1'b0;
			keep_r_q <= 1'b0;
			member_q <= 1'b0;
		end else begin
			live_q <= live_d;
			if (mode == M_EVAL_ADD) begin
				t_q     <= t_add;
				g_q     <= ~below_add;
				split_q <= 1'b0;
			end else if (mode == M_EVAL_REM) begin
				t_q     <= t_rem;
				split_q <= t_rem & keep_l & keep_r;
				g_q     <= (t_rem & keep_l & keep_r) | ~live_q | (lo_q > b);
			end
			if (mode == M_EVAL_ADD || mode == M_EVAL_REM) begin
				keep_l_q <= keep_l;
				keep_r_q <= keep_r;
				member_q <= live_q & (lo_q <= a) & (a <= hi_q);
			end
		end
	end

endmodule

// ----- rtl/sorted_interval_set_table_top.sv -----
// ----------------------------------------------------------------------------
// sorted_interval_set_table_top
// sorted table of disjoint intervals in a row of cells
// ----------------------------------------------------------------------------
// usage:
//  a request on in_valid/in_stall carries func, first_number, last_number;
//  func add inserts and joins an interval, remove cuts one out, query tests
//  first_number. each request gives one result on out_valid/out_stall:
//  is_member, status and interval_count after the request.
//  add and remove step through evaluate, apply, one neighbor exchange pass
//  per cell and finish; a query through evaluate and finish; a reversed
//  interval or an unused func goes straight to finish.
//  the exchange passes that close gaps in the cell row set the rate: one
//  request at a time, the next accepted once the result is registered.
//  in_stall is high while a request is in work.
//  a result waiting under out_stall holds; one further request may be
//  accepted and worked on, and it waits in its finish step until the
//  output register is free.
//  reset empties the table at once; the stored bounds are not cleared.
// ----------------------------------------------------------------------------
module sorted_interval_set_table_top import sis_pkg::*; #(
	parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
	parameter int NUMBER_BITS   = NUMBER_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                func,
	input  logic [FIELD_BITS-1:0]     first_number,
	input  logic [FIELD_BITS-1:0]     last_number,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      is_member,
	output logic [1:0]                status,
	output logic [COUNT_OUT_BITS-1:0] interval_count
);

	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int SW = $clog2(MAX_INTERVALS);
	localparam int IW = (NUMBER_BITS < FIELD_BITS) ? NUMBER_BITS : FIELD_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EVAL  = 5'b00010,
		S_APPLY = 5'b00100,
		S_SWAP  = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t                   state_q;
	logic [1:0]               func_q;
	logic [NUMBER_BITS-1:0]   a_q, b_q, a_in, b_in, hi_last;
	logic [1:0]               status_q;
	logic [SW-1:0]            sw_cnt_q;
	logic                     out_valid_q, member_out_q;
	logic [1:0]               status_out_q;
	logic [COUNT_OUT_BITS-1:0] count_out_q;
	cell_mode_t               mode;
	logic                     in_acc, fin_go, any_touch, any_split, any_member, full;
	logic [CW-1:0]            cnt;

	logic [NUMBER_BITS-1:0]   lo_a [MAX_INTERVALS];
	logic [NUMBER_BITS-1:0]   hi_a [MAX_INTERVALS];
	cell_flags_t              f_a  [MAX_INTERVALS];
	logic [MAX_INTERVALS-1:0] member_v, last_v, live_v, ends_v;

	assign a_in = NUMBER_BITS'(first_number[IW-1:0]);
	assign b_in = NUMBER_BITS'(last_number[IW-1:0]);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid & ~in_stall;
	assign fin_go   = (state_q == S_FIN) & (~out_valid_q | ~out_stall);
	assign full     = live_v[MAX_INTERVALS-1];

	always_comb begin
		any_touch  = 1'b0;
		any_split  = 1'b0;
		any_member = 1'b0;
		hi_last    = '0;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			any_touch  = any_touch | f_a[i].t;
			any_split  = any_split | f_a[i].split;
			any_member = any_member | member_v[i];
			hi_last    = hi_last | (last_v[i] ? hi_a[i] : '0);
		end
	end

	assign ends_v = live_v & ~(live_v >> 1);
	always_comb begin
		cnt = '0;
		for (int i = 0; i < MAX_INTERVALS; i++) begin
			cnt = cnt | (ends_v[i] ? CW'(i + 1) : '0);
		end
	end

	always_comb begin
		mode = M_HOLD;
		unique case (state_q)
			S_EVAL:  mode = (func_q == FUNC_ADD) ? M_EVAL_ADD : M_EVAL_REM;
			S_APPLY: begin
				if (func_q == FUNC_ADD) begin
					if (any_touch) begin
						mode = M_MERGE;
					end else if (!full) begin
						mode = M_INSERT;
					end
				end else if (any_split) begin
					if (!full) begin
						mode = M_INSERT;
					end
				end else begin
					mode = M_CUT;
				end
			end
			S_SWAP:  mode = sw_cnt_q[0] ? M_SWAP_ODD : M_SWAP_EVEN;
			default: mode = M_HOLD;
		endcase
	end

	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		logic [NUMBER_BITS-1:0] p_lo, p_hi, n_lo, n_hi;
		cell_flags_t            p_f, n_f;
		if (i == 0) begin : g_first
			assign p_lo = '0;
			assign p_hi = '0;
			assign p_f  = '{live: 1'b1, t: 1'b0, g: 1'b0, split: 1'b0};
		end else begin : g_mid
			assign p_lo = lo_a[i-1];
			assign p_hi = hi_a[i-1];
			assign p_f  = f_a[i-1];
		end
		if (i == MAX_INTERVALS - 1) begin : g_last
			assign n_lo = '0;
			assign n_hi = '0;
			assign n_f  = '{live: 1'b0, t: 1'b0, g: 1'b0, split: 1'b0};
		end else begin : g_below
			assign n_lo = lo_a[i+1];
			assign n_hi = hi_a[i+1];
			assign n_f  = f_a[i+1];
		end
		assign live_v[i] = f_a[i].live;
		sis_cell #(
			.NUMBER_BITS(NUMBER_BITS),
			.IDX_ODD    ((i % 2) == 1)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.mode   (mode),
			.a      (a_q),
			.b      (b_q),
			.hi_last(hi_last),
			.prev_lo(p_lo),
			.prev_hi(p_hi),
			.prev_f (p_f),
			.next_lo(n_lo),
			.next_hi(n_hi),
			.next_f (n_f),
			.lo     (lo_a[i]),
			.hi     (hi_a[i]),
			.f      (f_a[i]),
			.member (member_v[i]),
			.last_t (last_v[i])
		);
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q <= a_in;
			b_q <= b_in;
		end
		if (fin_go) begin
			member_out_q <= (func_q == FUNC_QUERY) & any_member;
			status_out_q <= status_q;
			count_out_q  <= COUNT_OUT_BITS'(cnt);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= FUNC_ADD;
			status_q    <= STATUS_DONE;
			sw_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						func_q <= func;
						if ((func == FUNC_ADD || func == FUNC_REMOVE) && a_in > b_in) begin
							status_q <= STATUS_REVERSED;
							state_q  <= S_FIN;
						end else if (func == FUNC_ADD || func == FUNC_REMOVE ||
							func == FUNC_QUERY) begin
							status_q <= STATUS_DONE;
							state_q  <= S_EVAL;
						end else begin
							status_q <= STATUS_DONE;
							state_q  <= S_FIN;
						end
					end
				end
				S_EVAL: begin
					state_q <= (func_q == FUNC_QUERY) ? S_FIN : S_APPLY;
				end
				S_APPLY: begin
					if (full && ((func_q == FUNC_ADD && !any_touch) ||
						(func_q == FUNC_REMOVE && any_split))) begin
						status_q <= STATUS_FULL;
					end
					sw_cnt_q <= '0;
					state_q  <= S_SWAP;
				end
				S_SWAP: begin
					sw_cnt_q <= sw_cnt_q + SW'(1);
					if (sw_cnt_q == SW'(MAX_INTERVALS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign is_member      = member_out_q;
	assign status         = status_out_q;
	assign interval_count = count_out_q;

`ifndef SYNTH
	// stored intervals always sit in the lowest cells between requests
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (live_v & (live_v + MAX_INTERVALS'(1))) == '0)
		else $error("gap in cell row at rest");

	// a full flag is only raised on a full table, and the table stays as it was
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_APPLY && status_q != STATUS_FULL && $past(state_q) == S_EVAL
		##1 status_q == STATUS_FULL |-> $past(full))
		else $error("full status on a table with room");

	// a result is only loaded while the output register is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(status_out_q) &&
		$stable(count_out_q))
		else $error("waiting result overwritten");

	// the table never holds more than its capacity
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> cnt <= CW'(MAX_INTERVALS))
		else $error("interval count beyond capacity");
`endif

endmodule

// ----- test/sorted_interval_set_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_interval_set_table_top_tb
// self-checking bench for the sorted interval set table
// ----------------------------------------------------------------------------
// a directed table covers empty-table replies, extremes of the number range,
// reversed intervals, the unused func, a full table and splits; random
// requests follow, mostly small-valued adds, removes and queries so that
// joins, cuts and full-table cases happen often. every result is checked
// field by field against an in-bench model of the table.
// ----------------------------------------------------------------------------
module sorted_interval_set_table_top_tb;
	import sis_pkg::*;

	localparam int DEPTH = MAX_INTERVALS_DEF;
	localparam logic [31:0] TOP = 32'hFFFF_FFFF;
	localparam logic [1:0] FUNC_NOP = 2'd3;
	localparam int N_RANDOM = 1600;

	typedef struct packed {
		logic       member;
		logic [1:0] stat;
		logic [4:0] count;
	} reply_t;

	typedef struct {
		logic [1:0]  f;
		logic [31:0] a;
		logic [31:0] b;
		logic        known;
		reply_t      r;
	} row_t;

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [1:0] func;
	logic [31:0] first_number, last_number;
	logic is_member;
	logic [1:0] status;
	logic [4:0] interval_count;

	logic [31:0] tbl_lo [DEPTH];
	logic [31:0] tbl_hi [DEPTH];
	int tbl_n;
	reply_t pending_replies[$];
	int errors;
	bit sending_done;
	row_t rows[$];

	sorted_interval_set_table_top dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] x);
		return (x == TOP) ? TOP : x + 1;
	endfunction

	function automatic void table_splice(int s, int e, logic [31:0] nl[2],
			logic [31:0] nh[2], int k);
		logic [31:0] lo2 [DEPTH];
		logic [31:0] hi2 [DEPTH];
		int j, m;
		m = 0;
		for (j = 0; j < s; j++) begin
			lo2[m] = tbl_lo[j]; hi2[m] = tbl_hi[j]; m++;
		end
		for (j = 0; j < k; j++) begin
			lo2[m] = nl[j]; hi2[m] = nh[j]; m++;
		end
		for (j = e; j < tbl_n; j++) begin
			lo2[m] = tbl_lo[j]; hi2[m] = tbl_hi[j]; m++;
		end
		for (j = 0; j < m; j++) begin
			tbl_lo[j] = lo2[j]; tbl_hi[j] = hi2[j];
		end
		tbl_n = m;
	endfunction

	function automatic reply_t table_apply(logic [1:0] f, logic [31:0] a,
			logic [31:0] b);
		reply_t r;
		int i, s, e, k;
		logic [31:0] nl[2], nh[2];
		r = '0;
		if (f == FUNC_ADD || f == FUNC_REMOVE) begin
			if (a > b) begin
				r.stat = STATUS_REVERSED;
			end else if (f == FUNC_ADD) begin
				i = 0;
				while (i < tbl_n && sat_inc(tbl_hi[i]) < a) i++;
				s = i;
				while (i < tbl_n && tbl_lo[i] <= sat_inc(b)) i++;
				e = i;
				if (s == e) begin
					if (tbl_n >= DEPTH) r.stat = STATUS_FULL;
					else begin
						nl[0] = a; nh[0] = b;
						table_splice(s, s, nl, nh, 1);
					end
				end else begin
					nl[0] = (tbl_lo[s] < a) ? tbl_lo[s] : a;
					nh[0] = (tbl_hi[e-1] > b) ? tbl_hi[e-1] : b;
					table_splice(s, e, nl, nh, 1);
				end
			end else begin
				i = 0;
				while (i < tbl_n && tbl_hi[i] < a) i++;
				s = i;
				while (i < tbl_n && tbl_lo[i] <= b) i++;
				e = i;
				k = 0;
				if (s != e) begin
					if (tbl_lo[s] < a) begin
						nl[k] = tbl_lo[s]; nh[k] = a - 1; k++;
					end
					if (tbl_hi[e-1] > b) begin
						nl[k] = b + 1; nh[k] = tbl_hi[e-1]; k++;
					end
					if (k > e - s && tbl_n >= DEPTH) r.stat = STATUS_FULL;
					else table_splice(s, e, nl, nh, k);
				end
			end
		end else if (f == FUNC_QUERY) begin
			for (i = 0; i < tbl_n; i++)
				if (tbl_lo[i] <= a && a <= tbl_hi[i]) r.member = 1;
		end
		r.count = tbl_n[4:0];
		return r;
	endfunction

	task automatic send_request(logic [1:0] f, logic [31:0] a, logic [31:0] b,
			logic known, reply_t kr);
		reply_t r;
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		r = table_apply(f, a, b);
		if (known && r != kr) begin
			$display("%0t: directed row mismatch expected %h actual model %h",
				$time, kr, r);
			errors++;
		end
		pending_replies.push_back(r);
		in_valid <= 1;
		func <= f;
		first_number <= a;
		last_number <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic [31:0] small_num();
		return $urandom_range(0, 80);
	endfunction

	function automatic void add_row(logic [1:0] f, logic [31:0] a, logic [31:0] b,
			logic known, logic m, logic [1:0] st, logic [4:0] c);
		row_t w;
		w.f = f; w.a = a; w.b = b; w.known = known;
		w.r.member = m; w.r.stat = st; w.r.count = c;
		rows.push_back(w);
	endfunction

	initial begin
		int i;
		logic [1:0] f;
		logic [31:0] a, b;
		arst_n = 0;
		in_valid = 0;
		func = FUNC_ADD;
		first_number = 0;
		last_number = 0;
		errors = 0;
		sending_done = 0;
		tbl_n = 0;
		add_row(FUNC_QUERY, 0, 0, 1, 0, STATUS_DONE, 0);
		add_row(FUNC_REMOVE, 0, TOP, 1, 0, STATUS_DONE, 0);
		add_row(FUNC_ADD, 5, 4, 1, 0, STATUS_REVERSED, 0);
		add_row(FUNC_REMOVE, TOP, 0, 1, 0, STATUS_REVERSED, 0);
		add_row(FUNC_NOP, TOP, TOP, 1, 0, STATUS_DONE, 0);
		add_row(FUNC_ADD, TOP, TOP, 1, 0, STATUS_DONE, 1);
		add_row(FUNC_QUERY, TOP, 0, 1, 1, STATUS_DONE, 1);
		add_row(FUNC_ADD, TOP - 1, TOP - 1, 1, 0, STATUS_DONE, 1);
		add_row(FUNC_ADD, 0, 0, 1, 0, STATUS_DONE, 2);
		add_row(FUNC_ADD, 1, 1, 1, 0, STATUS_DONE, 2);
		add_row(FUNC_REMOVE, 0, TOP, 1, 0, STATUS_DONE, 0);
		for (i = 0; i < DEPTH; i++)
			add_row(FUNC_ADD, 10 * i, 10 * i + 2, 0, 0, 0, 0);
		add_row(FUNC_ADD, 500, 600, 1, 0, STATUS_FULL, 16);
		add_row(FUNC_REMOVE, 1, 1, 1, 0, STATUS_FULL, 16);
		add_row(FUNC_ADD, 3, 9, 1, 0, STATUS_DONE, 15);
		add_row(FUNC_REMOVE, 0, 1000, 0, 0, 0, 0);
		add_row(FUNC_QUERY, 0, TOP, 1, 0, STATUS_DONE, 0);
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[j])
			send_request(rows[j].f, rows[j].a, rows[j].b, rows[j].known, rows[j].r);
		for (i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2) begin
				in_valid <= 0;
				while (pending_replies.size() != 0) @(posedge clk);
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: f = FUNC_ADD;
				4, 5, 6: f = FUNC_REMOVE;
				7, 8: f = FUNC_QUERY;
				default: f = FUNC_NOP;
			endcase
			if ($urandom_range(0, 19) == 0) begin
				a = $urandom; b = $urandom;
			end else if ($urandom_range(0, 19) == 0) begin
				a = TOP - small_num(); b = TOP - $urandom_range(0, 3);
			end else begin
				a = small_num();
				b = ($urandom_range(0, 9) == 0) ? small_num() : a + $urandom_range(0, 6);
			end
			send_request(f, a, b, 0, '0);
		end
		in_valid <= 0;
		sending_done = 1;
	end

	initial begin
		reply_t want, got;
		int hold;
		out_stall = 0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall && arst_n) begin
				got.member = is_member;
				got.stat = status;
				got.count = interval_count;
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected result actual %h", $time, got);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					if (got.member !== want.member) begin
						$display("%0t: is_member expected %b actual %b",
							$time, want.member, got.member);
						errors++;
					end
					if (got.stat !== want.stat) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.stat, got.stat);
						errors++;
					end
					if (got.count !== want.count) begin
						$display("%0t: interval_count expected %0d actual %0d",
							$time, want.count, got.count);
						errors++;
					end
				end
				hold = $urandom_range(0, 4);
				out_stall <= (hold != 0);
			end else if (hold > 0) begin
				hold--;
				out_stall <= (hold != 0);
			end
		end
	end

	initial begin
		wait (sending_done);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DEPTH + 10) @(posedge clk);
		if (errors == 0 && pending_replies.size() == 0)
			$display("** sorted_interval_set_table_top: PASSED **");
		else
			$display("** sorted_interval_set_table_top: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** sorted_interval_set_table_top: FAILED **");
		$finish;
	end

endmodule

// ----- sorted_interval_set_table_top.f -----
rtl/sis_pkg.sv
rtl/sis_cell.sv
rtl/sorted_interval_set_table_top.sv
test/sorted_interval_set_table_top_tb.sv
